### rtl/core/tppa_pkg.sv
// Shared types and constants for the tagged position packet averager.
// No dependencies.
package tppa_pkg;

  localparam int WINDOW_DEPTH_DEF = 4;
  localparam int NUM_LANES        = 4;
  localparam int BYTE_W           = 8;
  localparam int HALF_W           = 6;
  localparam int COORD_W          = 2 * HALF_W;
  localparam int POS_W            = 15;
  localparam int OUT_SHIFT        = 3;
  localparam int KIND_W           = 2;
  localparam int NUM_TAGS         = 4;

  localparam logic [KIND_W-1:0] KIND_POS_OK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POS_REJ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAL_ON  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CAL_OFF = 2'd3;

  localparam logic [1:0] TAG_X_LO = 2'd0;
  localparam logic [1:0] TAG_X_HI = 2'd1;
  localparam logic [1:0] TAG_Y_LO = 2'd2;
  localparam logic [1:0] TAG_Y_HI = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_Y = 8'h59;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_N = 8'h4E;

  typedef struct packed {
    logic [NUM_TAGS-1:0] tag_hot;
    logic [HALF_W-1:0]   payload;
  } lane_t;

  typedef struct packed {
    logic               push;
    logic               cal_set;
    logic               cal_clr;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pkt_t;

endpackage

### rtl/core/tppa_if.sv
// Valid/ready channel interfaces for packet input and position output.
// Depends on tppa_pkg.
interface tppa_in_if;
  logic                          valid;
  logic                          ready;
  logic [tppa_pkg::BYTE_W-1:0]   packet_byte0;
  logic [tppa_pkg::BYTE_W-1:0]   packet_byte1;
  logic [tppa_pkg::BYTE_W-1:0]   packet_byte2;
  logic [tppa_pkg::BYTE_W-1:0]   packet_byte3;

  modport source (output valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3,
                  input ready);
  modport sink   (input valid, packet_byte0, packet_byte1, packet_byte2, packet_byte3,
                  output ready);
endinterface

interface tppa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tppa_pkg::POS_W-1:0]    x_position;
  logic [tppa_pkg::POS_W-1:0]    y_position;
  logic [tppa_pkg::KIND_W-1:0]   packet_kind;
  logic                          calibration_mode;

  modport source (output valid, x_position, y_position, packet_kind, calibration_mode,
                  input ready);
  modport sink   (input valid, x_position, y_position, packet_kind, calibration_mode,
                  output ready);
endinterface

### rtl/core/tagged_position_packet_averager_unit.sv
// Tagged position packet averager, top level.
// The result beat is registered and goes valid in the cycle after the packet beat is accepted.
// One packet per cycle while the output is not stalled; window sum update and reciprocal multiply are combinational.
// Reset (rst_n, synchronous): windows, sums, held positions and calibration cleared.
// Depends on tppa_pkg, tppa_if, tppa_byte_lane, tppa_merge, tppa_window.
module tagged_position_packet_averager_unit #(
  parameter int WINDOW_DEPTH = tppa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tppa_in_if.sink    in_ch,
  tppa_out_if.source out_ch
);

  logic [tppa_pkg::BYTE_W-1:0] bytes [tppa_pkg::NUM_LANES];
  tppa_pkg::lane_t             lanes [tppa_pkg::NUM_LANES];
  tppa_pkg::pkt_t              pkt;
  logic                        accept;
  logic                        push;
  logic [tppa_pkg::POS_W-1:0]  x_pos_nxt;
  logic [tppa_pkg::POS_W-1:0]  y_pos_nxt;

  logic                        out_valid_r;
  logic [tppa_pkg::POS_W-1:0]  x_pos_r;
  logic [tppa_pkg::POS_W-1:0]  y_pos_r;
  logic [tppa_pkg::KIND_W-1:0] kind_r;
  logic                        cal_r;

  assign bytes[0] = in_ch.packet_byte0;
  assign bytes[1] = in_ch.packet_byte1;
  assign bytes[2] = in_ch.packet_byte2;
  assign bytes[3] = in_ch.packet_byte3;

  for (genvar g = 0; g < tppa_pkg::NUM_LANES; g++) begin : g_lane
    tppa_byte_lane u_lane (
      .byte_in (bytes[g]),
      .lane    (lanes[g])
    );
  end

  tppa_merge u_merge (
    .bytes_in (bytes),
    .lanes    (lanes),
    .pkt      (pkt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && pkt.push;

  tppa_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .sample  (pkt.x),
    .pos_nxt (x_pos_nxt)
  );

  tppa_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_win_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .sample  (pkt.y),
    .pos_nxt (y_pos_nxt)
  );

  // x/y output registers double as the held outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      x_pos_r     <= '0;
      y_pos_r     <= '0;
      cal_r       <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        x_pos_r <= x_pos_nxt;
        y_pos_r <= y_pos_nxt;
      end
      if (accept && pkt.cal_set) begin
        cal_r <= 1'b1;
      end else if (accept && pkt.cal_clr) begin
        cal_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= pkt.kind;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.x_position       = x_pos_r;
  assign out_ch.y_position       = y_pos_r;
  assign out_ch.packet_kind      = kind_r;
  assign out_ch.calibration_mode = cal_r;

`ifndef SYNTHESIS
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted packet produced no result beat");

  a_reject_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !pkt.push) |=> ($stable(x_pos_r) && $stable(y_pos_r)))
    else $error("position changed on a non-position beat");

  a_cal_on_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == tppa_pkg::KIND_CAL_ON) |-> cal_r)
    else $error("calibration-on beat without calibration mode");

  a_cal_off_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == tppa_pkg::KIND_CAL_OFF) |-> !cal_r)
    else $error("calibration-off beat with calibration mode set");
`endif

endmodule

### rtl/core/tppa_byte_lane.sv
// One byte lane: splits a packet byte into a one-hot tag and its payload.
// Depends on tppa_pkg.
module tppa_byte_lane (
  input  logic [tppa_pkg::BYTE_W-1:0] byte_in,
  output tppa_pkg::lane_t             lane
);

  always_comb begin
    case (byte_in[7:6])
      tppa_pkg::TAG_X_LO: lane.tag_hot = 4'b0001;
      tppa_pkg::TAG_X_HI: lane.tag_hot = 4'b0010;
      tppa_pkg::TAG_Y_LO: lane.tag_hot = 4'b0100;
      tppa_pkg::TAG_Y_HI: lane.tag_hot = 4'b1000;
      default:            lane.tag_hot = 4'b0000;
    endcase
    lane.payload = byte_in[tppa_pkg::HALF_W-1:0];
  end

endmodule

### rtl/core/tppa_merge.sv
// Merges the four byte lanes: tag check, coordinate assembly, calibration match.
// Depends on tppa_pkg.
module tppa_merge (
  input  logic [tppa_pkg::BYTE_W-1:0] bytes_in [tppa_pkg::NUM_LANES],
  input  tppa_pkg::lane_t             lanes    [tppa_pkg::NUM_LANES],
  output tppa_pkg::pkt_t              pkt
);

  logic [tppa_pkg::NUM_TAGS-1:0] seen;
  logic [tppa_pkg::HALF_W-1:0]   half [tppa_pkg::NUM_TAGS];
  logic                          is_cal_on;
  logic                          is_cal_off;
  logic                          tags_ok;

  always_comb begin
    for (int t = 0; t < tppa_pkg::NUM_TAGS; t++) begin
      seen[t] = 1'b0;
      half[t] = '0;
      for (int i = 0; i < tppa_pkg::NUM_LANES; i++) begin
        seen[t] = seen[t] | lanes[i].tag_hot[t];
        half[t] = half[t] | (lanes[i].tag_hot[t] ? lanes[i].payload : '0);
      end
    end
  end

  // four lanes, four tags: all seen means each seen exactly once
  assign tags_ok    = &seen;
  assign is_cal_on  = (bytes_in[0] == tppa_pkg::CHAR_Y) && (bytes_in[1] == tppa_pkg::CHAR_C) &&
                      (bytes_in[2] == tppa_pkg::CHAR_Y) && (bytes_in[3] == tppa_pkg::CHAR_C);
  assign is_cal_off = (bytes_in[0] == tppa_pkg::CHAR_N) && (bytes_in[1] == tppa_pkg::CHAR_C) &&
                      (bytes_in[2] == tppa_pkg::CHAR_N) && (bytes_in[3] == tppa_pkg::CHAR_C);

  always_comb begin
    pkt.cal_set = is_cal_on;
    pkt.cal_clr = is_cal_off && !is_cal_on;
    pkt.push    = !is_cal_on && !is_cal_off && tags_ok;
    pkt.x       = {half[1], half[0]};
    pkt.y       = {half[3], half[2]};
    if (is_cal_on) begin
      pkt.kind = tppa_pkg::KIND_CAL_ON;
    end else if (is_cal_off) begin
      pkt.kind = tppa_pkg::KIND_CAL_OFF;
    end else if (tags_ok) begin
      pkt.kind = tppa_pkg::KIND_POS_OK;
    end else begin
      pkt.kind = tppa_pkg::KIND_POS_REJ;
    end
  end

endmodule

### rtl/core/tppa_window.sv
// Moving-average window for one coordinate: shift line, running sum,
// reciprocal-multiply average scaled by 8. Depends on tppa_pkg.
module tppa_window #(
  parameter int WINDOW_DEPTH = tppa_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [tppa_pkg::COORD_W-1:0] sample,
  output logic [tppa_pkg::POS_W-1:0]   pos_nxt
);

  localparam int SUM_W   = $clog2(((1 << tppa_pkg::COORD_W) - 1) * WINDOW_DEPTH + 1);
  localparam int SHIFT   = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  logic [tppa_pkg::COORD_W-1:0] win_r [WINDOW_DEPTH];
  logic [SUM_W-1:0]             sum_r;
  logic [SUM_W-1:0]             sum_nxt;
  logic [PROD_W-1:0]            prod;
  logic [tppa_pkg::COORD_W-1:0] avg;

  assign sum_nxt = sum_r - SUM_W'(win_r[0]) + SUM_W'(sample);
  assign prod    = PROD_W'(sum_nxt) * PROD_W'(RECIP);
  assign avg     = prod[SHIFT +: tppa_pkg::COORD_W];
  assign pos_nxt = {avg, {tppa_pkg::OUT_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (push) begin
      sum_r <= sum_nxt;
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[WINDOW_DEPTH - 1] <= sample;
    end
  end

endmodule

### test/tagged_position_packet_averager_unit_tb.sv
// Testbench for tagged_position_packet_averager_unit: directed and random packet beats are
// checked against an in-bench window-average predictor, with random idling on both channels.
// Depends on tppa_pkg, tppa_if and the RTL of the unit.
module tagged_position_packet_averager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = tppa_pkg::WINDOW_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 10;

  typedef logic [tppa_pkg::NUM_LANES-1:0][tppa_pkg::BYTE_W-1:0] lanes_t;

  typedef struct packed {
    lanes_t lanes;
    logic   settle;
  } packet_item_t;

  typedef struct packed {
    logic [tppa_pkg::POS_W-1:0]  x;
    logic [tppa_pkg::POS_W-1:0]  y;
    logic [tppa_pkg::KIND_W-1:0] kind;
    logic                        cal;
  } position_beat_t;

  logic clk;
  logic rst_n;

  tppa_in_if  in_ch ();
  tppa_out_if out_ch ();

  tagged_position_packet_averager_unit #(.WINDOW_DEPTH(WIN)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  packet_item_t   packet_queue [$];
  position_beat_t pending_positions [$];

  logic [tppa_pkg::COORD_W-1:0] x_win [WIN];
  logic [tppa_pkg::COORD_W-1:0] y_win [WIN];
  int                           x_sum;
  int                           y_sum;
  logic [tppa_pkg::POS_W-1:0]   held_x;
  logic [tppa_pkg::POS_W-1:0]   held_y;
  logic                         cal_on;

  int   err_cnt;
  int   idle_cycles;
  logic in_taken;
  logic calm;
  int   in_gap;
  int   out_stall;

  always #1 clk = ~clk;

  task automatic predict_position(input lanes_t lanes, output position_beat_t res);
    logic [tppa_pkg::HALF_W-1:0]  half [tppa_pkg::NUM_TAGS];
    int                           seen [tppa_pkg::NUM_TAGS];
    logic [1:0]                   tag;
    logic [tppa_pkg::COORD_W-1:0] xv;
    logic [tppa_pkg::COORD_W-1:0] yv;
    bit                           all_once;
    if (lanes[0] == tppa_pkg::CHAR_Y && lanes[1] == tppa_pkg::CHAR_C &&
        lanes[2] == tppa_pkg::CHAR_Y && lanes[3] == tppa_pkg::CHAR_C) begin
      cal_on   = 1'b1;
      res.kind = tppa_pkg::KIND_CAL_ON;
    end else if (lanes[0] == tppa_pkg::CHAR_N && lanes[1] == tppa_pkg::CHAR_C &&
                 lanes[2] == tppa_pkg::CHAR_N && lanes[3] == tppa_pkg::CHAR_C) begin
      cal_on   = 1'b0;
      res.kind = tppa_pkg::KIND_CAL_OFF;
    end else begin
      for (int t = 0; t < tppa_pkg::NUM_TAGS; t++) begin
        half[t] = '0;
        seen[t] = 0;
      end
      for (int i = 0; i < tppa_pkg::NUM_LANES; i++) begin
        tag = lanes[i][tppa_pkg::BYTE_W-1 -: 2];
        half[tag] = lanes[i][tppa_pkg::HALF_W-1:0];
        seen[tag]++;
      end
      all_once = 1'b1;
      for (int t = 0; t < tppa_pkg::NUM_TAGS; t++) begin
        if (seen[t] != 1) all_once = 1'b0;
      end
      if (all_once) begin
        xv = {half[tppa_pkg::TAG_X_HI], half[tppa_pkg::TAG_X_LO]};
        yv = {half[tppa_pkg::TAG_Y_HI], half[tppa_pkg::TAG_Y_LO]};
        x_sum = x_sum - int'(x_win[0]) + int'(xv);
        y_sum = y_sum - int'(y_win[0]) + int'(yv);
        for (int i = 0; i < WIN - 1; i++) begin
          x_win[i] = x_win[i+1];
          y_win[i] = y_win[i+1];
        end
        x_win[WIN-1] = xv;
        y_win[WIN-1] = yv;
        held_x = tppa_pkg::POS_W'((x_sum / WIN) << tppa_pkg::OUT_SHIFT);
        held_y = tppa_pkg::POS_W'((y_sum / WIN) << tppa_pkg::OUT_SHIFT);
        res.kind = tppa_pkg::KIND_POS_OK;
      end else begin
        res.kind = tppa_pkg::KIND_POS_REJ;
      end
    end
    res.x   = held_x;
    res.y   = held_y;
    res.cal = cal_on;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [tppa_pkg::HALF_W-1:0] pick_half();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return tppa_pkg::HALF_W'($urandom);
  endfunction

  function automatic lanes_t pos_lanes(input logic [tppa_pkg::HALF_W-1:0] xlo,
                                       input logic [tppa_pkg::HALF_W-1:0] xhi,
                                       input logic [tppa_pkg::HALF_W-1:0] ylo,
                                       input logic [tppa_pkg::HALF_W-1:0] yhi);
    return {tppa_pkg::TAG_Y_HI, yhi, tppa_pkg::TAG_Y_LO, ylo,
            tppa_pkg::TAG_X_HI, xhi, tppa_pkg::TAG_X_LO, xlo};
  endfunction

  function automatic lanes_t cal_lanes(input logic [tppa_pkg::BYTE_W-1:0] a,
                                       input logic [tppa_pkg::BYTE_W-1:0] b);
    return {b, a, b, a};
  endfunction

  function automatic lanes_t shuffle_lanes(input lanes_t l);
    lanes_t                      s;
    int                          j;
    logic [tppa_pkg::BYTE_W-1:0] tmp;
    s = l;
    for (int i = tppa_pkg::NUM_LANES - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = s[i];
      s[i] = s[j];
      s[j] = tmp;
    end
    return s;
  endfunction

  function automatic lanes_t random_position();
    return shuffle_lanes(pos_lanes(pick_half(), pick_half(), pick_half(), pick_half()));
  endfunction

  task automatic queue_packet(input lanes_t l, input logic settle);
    packet_item_t item;
    item.lanes  = l;
    item.settle = settle;
    packet_queue.push_back(item);
  endtask

  // driver: one beat per item, held until taken
  always @(negedge clk) begin : driver
    packet_item_t item;
    if (rst_n) begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (!in_ch.valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (packet_queue.size() != 0 &&
                     !(packet_queue[0].settle && pending_positions.size() != 0)) begin
          item = packet_queue.pop_front();
          in_ch.packet_byte0 <= item.lanes[0];
          in_ch.packet_byte1 <= item.lanes[1];
          in_ch.packet_byte2 <= item.lanes[2];
          in_ch.packet_byte3 <= item.lanes[3];
          in_ch.valid        <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk) begin : monitor
    position_beat_t predicted;
    position_beat_t got;
    bit             any_beat;
    if (rst_n) begin
      any_beat = 1'b0;
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_position({in_ch.packet_byte3, in_ch.packet_byte2,
                          in_ch.packet_byte1, in_ch.packet_byte0}, predicted);
        pending_positions.push_back(predicted);
        any_beat = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        any_beat = 1'b1;
        if (pending_positions.size() == 0) begin
          $error("result beat with no packet pending");
          err_cnt++;
        end else begin
          predicted = pending_positions.pop_front();
          got.x    = out_ch.x_position;
          got.y    = out_ch.y_position;
          got.kind = out_ch.packet_kind;
          got.cal  = out_ch.calibration_mode;
          check_field("x_position", predicted.x, got.x);
          check_field("y_position", predicted.y, got.y);
          check_field("packet_kind", predicted.kind, got.kind);
          check_field("calibration_mode", predicted.cal, got.cal);
        end
      end
      if (any_beat) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    lanes_t l;
    int     r;
    int     i;
    int     j;
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.packet_byte0 = '0;
    in_ch.packet_byte1 = '0;
    in_ch.packet_byte2 = '0;
    in_ch.packet_byte3 = '0;
    out_ch.ready       = 1'b0;
    err_cnt            = 0;
    idle_cycles        = 0;
    in_taken           = 1'b0;
    calm               = 1'b0;
    in_gap             = 0;
    out_stall          = 0;
    for (int k = 0; k < WIN; k++) begin
      x_win[k] = '0;
      y_win[k] = '0;
    end
    x_sum  = 0;
    y_sum  = 0;
    held_x = '0;
    held_y = '0;
    cal_on = 1'b0;

    // directed
    queue_packet(pos_lanes('0, '0, '0, '0), 1'b0);
    queue_packet(cal_lanes(tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C), 1'b0);
    queue_packet(cal_lanes(tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C), 1'b0);
    queue_packet(pos_lanes('1, '1, '1, '1), 1'b0);
    queue_packet(cal_lanes(tppa_pkg::CHAR_N, tppa_pkg::CHAR_C), 1'b0);
    queue_packet(cal_lanes(tppa_pkg::CHAR_N, tppa_pkg::CHAR_C), 1'b0);
    queue_packet({tppa_pkg::CHAR_N, tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C, tppa_pkg::CHAR_Y}, 1'b0);
    queue_packet({tppa_pkg::CHAR_C, tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C, tppa_pkg::CHAR_N}, 1'b0);
    for (int k = 0; k < WIN; k++) queue_packet(pos_lanes('1, '1, '1, '1), 1'b0);
    queue_packet({8'h3F, 8'h7F, 8'hBF, 8'hFF}, 1'b0);
    queue_packet({8'h00, 8'h80, 8'h40, 8'hC0}, 1'b0);
    queue_packet('1, 1'b0);
    queue_packet('0, 1'b0);
    queue_packet({8'h40, 8'h80, 8'h00, 8'h3F}, 1'b0);
    queue_packet({8'hC0, 8'h80, 8'h40, 8'hFF}, 1'b0);
    queue_packet(pos_lanes(6'h15, 6'h2A, 6'h2A, 6'h15), 1'b0);
    for (int k = 0; k < WIN; k++) queue_packet(pos_lanes('0, '0, '0, '0), 1'b0);

    // random
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        l = random_position();
      end else if (r < 76) begin
        l = $urandom_range(0, 1) ? cal_lanes(tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C) :
                                   cal_lanes(tppa_pkg::CHAR_N, tppa_pkg::CHAR_C);
      end else if (r < 80) begin
        l = $urandom_range(0, 1) ? cal_lanes(tppa_pkg::CHAR_Y, tppa_pkg::CHAR_C) :
                                   cal_lanes(tppa_pkg::CHAR_N, tppa_pkg::CHAR_C);
        l[$urandom_range(0, tppa_pkg::NUM_LANES - 1)] = tppa_pkg::BYTE_W'($urandom);
      end else if (r < 90) begin
        l = random_position();
        i = $urandom_range(0, tppa_pkg::NUM_LANES - 1);
        j = (i + $urandom_range(1, tppa_pkg::NUM_LANES - 1)) % tppa_pkg::NUM_LANES;
        l[i][tppa_pkg::BYTE_W-1 -: 2] = l[j][tppa_pkg::BYTE_W-1 -: 2];
      end else begin
        l = lanes_t'($urandom);
      end
      queue_packet(l, (n % 400) == 0);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (packet_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_positions.size() != 0) begin
      $error("%0d results never arrived", pending_positions.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### tagged_position_packet_averager_unit.f
rtl/core/tppa_pkg.sv
rtl/core/tppa_if.sv
rtl/core/tppa_byte_lane.sv
rtl/core/tppa_merge.sv
rtl/core/tppa_window.sv
rtl/core/tagged_position_packet_averager_unit.sv
test/tagged_position_packet_averager_unit_tb.sv
